### rtl/sdel_pkg.sv
// ----------------------------------------------------------------------------
// sdel_pkg: shared types and constants for the searchable double-ended list
// Word formats, operation classes and result status codes.
// ----------------------------------------------------------------------------
package sdel_pkg;

  // default list depth
  localparam int DEF_CAPACITY = 16;

  // fixed field widths
  localparam int MODE_W = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int OCC_W  = 5;

  // command mode codes as seen on the input word
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_UPDATE     = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_NOTFOUND = 2'd3;

  // operation class after decode
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_UPDATE     = 3'd5,
    OP_NOP        = 3'd6
  } op_t;

  // input word
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
  } in_item_t;

  // result word
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] removed_value;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // classified command held in the queue
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
  } cmd_t;

  // queue status toward the back end
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } q_head_t;

endpackage

### rtl/searchable_double_ended_list_top.sv
// ----------------------------------------------------------------------------
// searchable_double_ended_list_top: bounded deque with search and update
// Front end decodes commands into a short queue; back end runs them on a
// circular list held in RAM.
//
//   channel  ports                      flow
//   -------  -------------------------  ----------------------------------
//   input    start, busy, in_data       word taken when start && !busy
//   result   out_valid, out_data        one-cycle strobe, cannot be held
//
// Push, unused modes and any command on an empty list are answered straight
// from the idle state; pop takes one RAM read in a pop state; search and
// update scan the list, reading one entry per cycle, until a hit or the last
// entry. The two-entry queue raises busy when full.
// Reset (rst_n low, synchronous) empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
module searchable_double_ended_list_top #(
  parameter int CAPACITY = sdel_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sdel_pkg::in_item_t  in_data,
  output logic                out_valid,
  output sdel_pkg::out_item_t out_data
);
  import sdel_pkg::*;

  q_head_t head;
  logic    deq;

  // intake and classify
  sdel_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_data(in_data),
    .deq    (deq),
    .head   (head)
  );

  // execute on the list
  sdel_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .deq      (deq),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

### rtl/sdel_ram.sv
// ----------------------------------------------------------------------------
// sdel_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/sdel_front.sv
// ----------------------------------------------------------------------------
// sdel_front: command intake
// Accepts input words, decodes the mode into an operation class and holds
// them in a two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module sdel_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sdel_pkg::in_item_t in_data,
  input  logic               deq,
  output sdel_pkg::q_head_t  head
);
  import sdel_pkg::*;

  localparam int QDEPTH = 2;

  cmd_t       q_mem_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       enq;
  logic       do_deq;
  cmd_t       new_cmd;

  // mode decode
  always_comb begin
    new_cmd.value     = in_data.value;
    new_cmd.new_value = in_data.new_value;
    unique case (in_data.mode)
      MODE_PUSH_FRONT: new_cmd.op = OP_PUSH_FRONT;
      MODE_PUSH_BACK:  new_cmd.op = OP_PUSH_BACK;
      MODE_POP_FRONT:  new_cmd.op = OP_POP_FRONT;
      MODE_POP_BACK:   new_cmd.op = OP_POP_BACK;
      MODE_SEARCH:     new_cmd.op = OP_SEARCH;
      MODE_UPDATE:     new_cmd.op = OP_UPDATE;
      default:         new_cmd.op = OP_NOP;
    endcase
  end

  // queue control
  assign busy   = (q_cnt_r == 2'(QDEPTH));
  assign enq    = start && !busy;
  assign do_deq = deq && (q_cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = enq ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_deq ? ~rd_ptr_r : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r + 2'(enq) - 2'(do_deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

  assign head.vld = (q_cnt_r != 2'd0);
  assign head.cmd = q_mem_r[rd_ptr_r];

`ifndef ASSERT_OFF
  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'(QDEPTH))
    else $error("command queue over capacity");
`endif

endmodule

### rtl/sdel_back.sv
// ----------------------------------------------------------------------------
// sdel_back: list execution
// Holds the circular list, carries out one queued command at a time and
// drives the one-cycle result strobe. Search walks the entries through the
// RAM read port, one entry per cycle.
// ----------------------------------------------------------------------------
module sdel_back #(
  parameter int CAPACITY = sdel_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdel_pkg::q_head_t   head,
  output logic                deq,
  output logic                out_valid,
  output sdel_pkg::out_item_t out_data
);
  import sdel_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = IDX_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] issue_k_r, issue_k_nxt;
  logic [IDX_W-1:0] cmp_k_r, cmp_k_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // physical slot of logical position k
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(k);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  // entry storage
  sdel_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // command sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    issue_k_nxt  = issue_k_r;
    cmp_k_nxt    = cmp_k_r;
    cmp_vld_nxt  = 1'b0;
    out_vld_nxt  = 1'b0;
    out_item_nxt = out_item_r;
    deq          = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = front_r;
    ram_wdata    = cmd_r.value;
    ram_raddr    = slot_of(front_r, issue_k_r);

    unique case (state_r)
      ST_IDLE: begin
        if (head.vld) begin
          deq     = 1'b1;
          cmd_nxt = head.cmd;
          out_item_nxt.status        = STATUS_OK;
          out_item_nxt.position      = '0;
          out_item_nxt.removed_value = '0;
          out_item_nxt.occupancy     = OCC_W'(count_r);
          unique case (head.cmd.op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              out_vld_nxt = 1'b1;
              if (count_r == CNT_W'(CAPACITY)) begin
                out_item_nxt.status = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = head.cmd.value;
                if (head.cmd.op == OP_PUSH_FRONT) begin
                  front_nxt = (front_r == '0) ? IDX_W'(CAPACITY - 1)
                                              : front_r - IDX_W'(1);
                  ram_waddr = front_nxt;
                end else begin
                  ram_waddr = slot_of(front_r, count_r);
                end
                count_nxt              = count_r + CNT_W'(1);
                out_item_nxt.occupancy = OCC_W'(count_nxt);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count_r == '0) begin
                out_vld_nxt         = 1'b1;
                out_item_nxt.status = STATUS_EMPTY;
              end else begin
                ram_raddr = (head.cmd.op == OP_POP_FRONT) ? front_r
                          : slot_of(front_r, count_r - CNT_W'(1));
                state_nxt = ST_POP;
              end
            end
            OP_SEARCH, OP_UPDATE: begin
              if (count_r == '0) begin
                out_vld_nxt         = 1'b1;
                out_item_nxt.status = STATUS_NOTFOUND;
              end else begin
                issue_k_nxt = '0;
                state_nxt   = ST_SCAN;
              end
            end
            default: begin
              out_vld_nxt = 1'b1;
            end
          endcase
        end
      end

      // read data of the popped slot is valid here
      ST_POP: begin
        if (cmd_r.op == OP_POP_FRONT) begin
          front_nxt = (front_r == IDX_W'(CAPACITY - 1)) ? '0 : front_r + IDX_W'(1);
        end
        count_nxt                  = count_r - CNT_W'(1);
        out_vld_nxt                = 1'b1;
        out_item_nxt.removed_value = ram_rdata;
        out_item_nxt.occupancy     = OCC_W'(count_nxt);
        state_nxt                  = ST_IDLE;
      end

      // issue one read per cycle, compare the one issued last cycle
      ST_SCAN: begin
        if (issue_k_r < count_r) begin
          issue_k_nxt = issue_k_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_k_nxt   = issue_k_r[IDX_W-1:0];
        end
        if (cmp_vld_r) begin
          if (ram_rdata == cmd_r.value) begin
            out_vld_nxt           = 1'b1;
            out_item_nxt.position = POS_W'(cmp_k_r);
            cmp_vld_nxt           = 1'b0;
            state_nxt             = ST_IDLE;
            if (cmd_r.op == OP_UPDATE) begin
              ram_we    = 1'b1;
              ram_waddr = slot_of(front_r, CNT_W'(cmp_k_r));
              ram_wdata = cmd_r.new_value;
            end
          end else if (CNT_W'(cmp_k_r) == count_r - CNT_W'(1)) begin
            out_vld_nxt         = 1'b1;
            out_item_nxt.status = STATUS_NOTFOUND;
            cmp_vld_nxt         = 1'b0;
            state_nxt           = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      front_r   <= '0;
      issue_k_r <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      front_r   <= front_nxt;
      issue_k_r <= issue_k_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cmp_k_r    <= cmp_k_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

`ifndef ASSERT_OFF
  // fill level stays within the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // front pointer stays on a real slot
  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= IDX_W'(CAPACITY - 1))
    else $error("front pointer out of range");

  // occupancy only moves together with a result strobe
  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_vld_r)
    else $error("occupancy changed without a result");

  // a new command is only taken when the sequencer is idle
  a_deq_idle: assert property (@(posedge clk) disable iff (!rst_n)
    deq |-> (state_r == ST_IDLE) && head.vld)
    else $error("command taken while busy");
`endif

endmodule
